// ===== design/cubic_bezier_link_tessellator_unit_defines.svh =====
// Assertion macros for the cubic Bezier link tessellator.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef CUBIC_BEZIER_LINK_TESSELLATOR_UNIT_DEFINES_SVH
`define CUBIC_BEZIER_LINK_TESSELLATOR_UNIT_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define CBLT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("cblt: same-cycle check failed");
// Next-cycle implication, disabled during reset
`define CBLT_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("cblt: next-cycle check failed");
`else
`define CBLT_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define CBLT_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== design/cblt_pkg.sv =====
// Shared widths, constants, stage types and rounding helpers of the tessellator.
// No dependencies; imported by the interfaces and every module.
package cblt_pkg;

    localparam int CRD_W       = 16;   // Q12.4 coordinate
    localparam int SEG_W       = 6;    // segment count and point index
    localparam int T_W         = 17;   // t and u, Q1.16
    localparam int SQ_W        = 34;   // second-order products
    localparam int CUBE_W      = 51;   // third-order products, Q.48
    localparam int WGT_W       = 34;   // weights and weight sums, Q.32
    localparam int MID_W       = 18;   // doubled coordinates
    localparam int SUM_W       = 54;   // weighted sums, 2^-33 LSB
    localparam int WGT_SHIFT   = 16;
    localparam int RND_SHIFT   = 33;
    localparam int RND_W       = SUM_W - RND_SHIFT;
    localparam int CNT_W       = 5;    // reciprocal step counter

    localparam logic [SEG_W-1:0]  SEG_RESET  = SEG_W'(16);
    localparam logic [SEG_W-1:0]  SEG_MIN    = SEG_W'(1);
    localparam logic [T_W-1:0]    T_ONE      = T_W'(65536);
    localparam logic [CNT_W-1:0]  RCP_STEPS  = CNT_W'(T_W - 1);
    localparam logic [CUBE_W:0]   WGT_RND    = (CUBE_W+1)'(1) << (WGT_SHIFT - 1);
    localparam logic [SUM_W-1:0]  SUM_RND    = SUM_W'(1) << (RND_SHIFT - 1);
    localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(32767);
    localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(-32768);

    typedef struct packed {
        logic signed [CRD_W-1:0] sx;
        logic signed [CRD_W-1:0] sy;
        logic signed [CRD_W-1:0] ex;
        logic signed [CRD_W-1:0] ey;
    } cblt_pts_t;

    typedef struct packed {
        logic [SEG_W-1:0] idx;
        logic             last;
    } cblt_meta_t;

    typedef struct packed {
        logic       valid;
        logic [T_W-1:0] t;
        cblt_pts_t  pts;
        cblt_meta_t meta;
    } cblt_issue_t;

    typedef struct packed {
        logic                    valid;
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic [SEG_W-1:0]        idx;
        logic                    last;
    } cblt_point_t;

    typedef struct packed {
        logic             busy;
        logic [T_W-1:0]   quot;
        logic [SEG_W-1:0] rem;
    } cblt_recip_t;

    // Round a Q.48 product to a Q.32 weight, half up
    function automatic logic [WGT_W-1:0] rnd_wgt(input logic [CUBE_W:0] m);
        logic [CUBE_W:0] s;
        s = m + WGT_RND;
        return WGT_W'(s >> WGT_SHIFT);
    endfunction

    // Unsigned weight times signed doubled coordinate
    function automatic logic signed [SUM_W-1:0] wmul(input logic [WGT_W-1:0] w,
                                                     input logic signed [MID_W-1:0] c);
        logic signed [SUM_W-1:0] we;
        logic signed [SUM_W-1:0] ce;
        we = $signed(SUM_W'(w));
        ce = SUM_W'(c);
        return we * ce;
    endfunction

    // Round to nearest (ties up) and saturate to the coordinate range
    function automatic logic signed [CRD_W-1:0] sat_rnd(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] b;
        logic signed [RND_W-1:0] r;
        b = s + $signed(SUM_RND);
        r = RND_W'(b >>> RND_SHIFT);
        if (r > SAT_HI) begin
            return CRD_W'(SAT_HI);
        end
        else if (r < SAT_LO) begin
            return CRD_W'(SAT_LO);
        end
        return CRD_W'(r);
    endfunction

endpackage

// ===== design/cblt_if.sv =====
// Valid/ready channel interfaces for curve endpoints and tessellated points.
// Depends on cblt_pkg for field widths.
interface cblt_curve_if
    import cblt_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [CRD_W-1:0] start_x;
    logic signed [CRD_W-1:0] start_y;
    logic signed [CRD_W-1:0] end_x;
    logic signed [CRD_W-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface cblt_point_if
    import cblt_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [CRD_W-1:0] point_x;
    logic signed [CRD_W-1:0] point_y;
    logic [SEG_W-1:0]        point_index;
    logic                    last_point;

    modport source (output valid, point_x, point_y, point_index, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_index, last_point, output ready);
endinterface

// ===== design/cblt_recip.sv =====
// Bit-serial restoring divider: 65536 / segment count, quotient and remainder.
// Depends on cblt_pkg; runs after reset and after each segment count write.
module cblt_recip
    import cblt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SEG_W-1:0] seg,
    output cblt_recip_t      rcp
);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [T_W-1:0]   quot_reg;
    logic [SEG_W-1:0] rem_reg;
    logic [SEG_W:0]   shift_next;
    logic             fit_next;
    logic [SEG_W-1:0] rem_next;

    // Dividend is 1 followed by sixteen zeros: only the first bit shifted in is set
    always_comb
    begin
        shift_next = {rem_reg, (cnt_reg == '0)};
        fit_next   = (shift_next >= {1'b0, seg});
        rem_next   = fit_next ? SEG_W'(shift_next - {1'b0, seg}) : SEG_W'(shift_next);
    end

    // Iterate one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[T_W-2:0], fit_next};
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_reg + CNT_W'(1);
            if (cnt_reg == RCP_STEPS)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign rcp.busy = busy_reg;
    assign rcp.quot = quot_reg;
    assign rcp.rem  = rem_reg;

endmodule

// ===== design/cblt_pipe.sv =====
// Seven-stage Bernstein evaluation pipeline: weights, products, sum, round.
// Depends on cblt_pkg; all stages move together on the advance strobe.
module cblt_pipe
    import cblt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  cblt_issue_t iss,
    output cblt_point_t out
);

    // Stage 1: t, u and second-order products
    logic [T_W-1:0]  s1_t_reg, s1_u_reg, u_next;
    logic [SQ_W-1:0] s1_u2_reg, s1_t2_reg, s1_ut_reg;
    cblt_pts_t       s1_pts_reg;
    cblt_meta_t      s1_meta_reg;
    // Stage 2: third-order products
    logic [CUBE_W-1:0] s2_m1_reg, s2_m2_reg, s2_m3_reg, s2_m4_reg;
    cblt_pts_t         s2_pts_reg;
    cblt_meta_t        s2_meta_reg;
    // Stage 3: rounded weights
    logic [WGT_W-1:0] s3_w1_reg, s3_w2_reg, s3_w3_reg, s3_w4_reg;
    cblt_pts_t        s3_pts_reg;
    cblt_meta_t       s3_meta_reg;
    // Stage 4: combined weights and doubled coordinates
    logic [WGT_W-1:0]        s4_wx0_reg, s4_wx1_reg, s4_wx2_reg, s4_wy0_reg, s4_wy1_reg;
    logic signed [MID_W-1:0] s4_cx0_reg, s4_cxm_reg, s4_cx1_reg, s4_cy0_reg, s4_cy1_reg;
    cblt_meta_t              s4_meta_reg;
    // Stage 5: partial products
    logic signed [SUM_W-1:0] s5_px0_reg, s5_px1_reg, s5_px2_reg, s5_py0_reg, s5_py1_reg;
    cblt_meta_t              s5_meta_reg;
    // Stage 6: sums
    logic signed [SUM_W-1:0] s6_px_reg, s6_py_reg;
    cblt_meta_t              s6_meta_reg;
    // Output register
    logic signed [CRD_W-1:0] out_x_reg, out_y_reg;
    cblt_meta_t              out_meta_reg;
    // Valid bits, one per stage
    logic [6:0] vld_reg;

    assign u_next = T_ONE - iss.t;

    // Advance the payload of every stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_t_reg    <= iss.t;
            s1_u_reg    <= u_next;
            s1_u2_reg   <= SQ_W'(u_next) * SQ_W'(u_next);
            s1_t2_reg   <= SQ_W'(iss.t) * SQ_W'(iss.t);
            s1_ut_reg   <= SQ_W'(u_next) * SQ_W'(iss.t);
            s1_pts_reg  <= iss.pts;
            s1_meta_reg <= iss.meta;

            s2_m1_reg   <= CUBE_W'(s1_u2_reg) * CUBE_W'(s1_u_reg);
            s2_m2_reg   <= CUBE_W'(s1_ut_reg) * CUBE_W'(s1_u_reg);
            s2_m3_reg   <= CUBE_W'(s1_ut_reg) * CUBE_W'(s1_t_reg);
            s2_m4_reg   <= CUBE_W'(s1_t2_reg) * CUBE_W'(s1_t_reg);
            s2_pts_reg  <= s1_pts_reg;
            s2_meta_reg <= s1_meta_reg;

            s3_w1_reg   <= rnd_wgt((CUBE_W+1)'(s2_m1_reg));
            s3_w2_reg   <= rnd_wgt((CUBE_W+1)'(s2_m2_reg) * (CUBE_W+1)'(3));
            s3_w3_reg   <= rnd_wgt((CUBE_W+1)'(s2_m3_reg) * (CUBE_W+1)'(3));
            s3_w4_reg   <= rnd_wgt((CUBE_W+1)'(s2_m4_reg));
            s3_pts_reg  <= s2_pts_reg;
            s3_meta_reg <= s2_meta_reg;

            // Inner control points share the midpoint x; y follows start or end
            s4_wx0_reg  <= s3_w1_reg;
            s4_wx1_reg  <= s3_w2_reg + s3_w3_reg;
            s4_wx2_reg  <= s3_w4_reg;
            s4_wy0_reg  <= s3_w1_reg + s3_w2_reg;
            s4_wy1_reg  <= s3_w3_reg + s3_w4_reg;
            s4_cx0_reg  <= MID_W'(s3_pts_reg.sx) <<< 1;
            s4_cxm_reg  <= MID_W'(s3_pts_reg.sx) + MID_W'(s3_pts_reg.ex);
            s4_cx1_reg  <= MID_W'(s3_pts_reg.ex) <<< 1;
            s4_cy0_reg  <= MID_W'(s3_pts_reg.sy) <<< 1;
            s4_cy1_reg  <= MID_W'(s3_pts_reg.ey) <<< 1;
            s4_meta_reg <= s3_meta_reg;

            s5_px0_reg  <= wmul(s4_wx0_reg, s4_cx0_reg);
            s5_px1_reg  <= wmul(s4_wx1_reg, s4_cxm_reg);
            s5_px2_reg  <= wmul(s4_wx2_reg, s4_cx1_reg);
            s5_py0_reg  <= wmul(s4_wy0_reg, s4_cy0_reg);
            s5_py1_reg  <= wmul(s4_wy1_reg, s4_cy1_reg);
            s5_meta_reg <= s4_meta_reg;

            s6_px_reg   <= s5_px0_reg + s5_px1_reg + s5_px2_reg;
            s6_py_reg   <= s5_py0_reg + s5_py1_reg;
            s6_meta_reg <= s5_meta_reg;

            out_x_reg    <= sat_rnd(s6_px_reg);
            out_y_reg    <= sat_rnd(s6_py_reg);
            out_meta_reg <= s6_meta_reg;
        end
    end

    // Shift valid bits along with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[5:0], iss.valid};
        end
    end

    assign out.valid = vld_reg[6];
    assign out.x     = out_x_reg;
    assign out.y     = out_y_reg;
    assign out.idx   = out_meta_reg.idx;
    assign out.last  = out_meta_reg.last;

endmodule

// ===== design/cubic_bezier_link_tessellator_unit.sv =====
// Cubic Bezier link tessellator: top level with segment register and point sequencer.
// Depends on cblt_pkg, cblt_if, cblt_recip, cblt_pipe and the assertion macro header.
//
//   channel   dir   transaction carries
//   -------   ---   -------------------------------------------------------
//   curve     in    start_x, start_y, end_x, end_y (Q12.4)
//   point     out   point_x, point_y (Q12.4), point_index, last_point
//   cfg       in    cfg_wr_en / cfg_wr_data: segment count, no read-back
//
// A curve yields segment_count + 1 points (a zero count acts as one), one point per
// cycle out of the sequencer unless the output stalls; the next curve is taken in the
// cycle its predecessor's last point issues. An accepted curve's start point passes
// the issue register and the pipeline stages. After reset and after each count write,
// a bit-serial divider forms 65536 / count; no curve is taken while it runs.
// A stalled point freezes the whole pipeline and the sequencer; nothing is dropped.
`include "cubic_bezier_link_tessellator_unit_defines.svh"
module cubic_bezier_link_tessellator_unit
    import cblt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [SEG_W-1:0]  cfg_wr_data,
    cblt_curve_if.sink        curve,
    cblt_point_if.source      point
);

    logic [SEG_W-1:0] seg_reg;
    logic [SEG_W-1:0] seg_eff;
    logic             busy_reg;
    cblt_pts_t        pts_reg;
    logic [SEG_W-1:0] idx_reg;
    logic [T_W-1:0]   t_reg, t_next;
    logic [SEG_W-1:0] r_reg, r_next;
    logic [SEG_W:0]   r_sum;
    logic             last_now;
    logic             adv;
    logic             accept;
    cblt_issue_t      iss_reg;
    cblt_recip_t      rcp;
    cblt_point_t      pout;

    assign seg_eff = (seg_reg == '0) ? SEG_MIN : seg_reg;

    // Hold the segment count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= SEG_RESET;
        end
        else if (cfg_wr_en)
        begin
            seg_reg <= cfg_wr_data;
        end
    end

    cblt_recip u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_wr_en),
        .seg   (seg_eff),
        .rcp   (rcp)
    );

    // Step t by 65536/seg as quotient plus carried remainder
    always_comb
    begin
        r_sum = {1'b0, r_reg} + {1'b0, rcp.rem};
        if (r_sum >= {1'b0, seg_eff})
        begin
            t_next = t_reg + rcp.quot + T_W'(1);
            r_next = SEG_W'(r_sum - {1'b0, seg_eff});
        end
        else
        begin
            t_next = t_reg + rcp.quot;
            r_next = SEG_W'(r_sum);
        end
    end

    assign adv         = !pout.valid || point.ready;
    assign last_now    = (idx_reg == seg_eff);
    assign curve.ready = !rcp.busy && (!busy_reg || (adv && last_now));
    assign accept      = curve.valid && curve.ready;

    // Sequence the points of one curve into the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iss_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (adv && last_now)
            begin
                busy_reg <= 1'b0;
            end
            if (adv)
            begin
                iss_reg.valid     <= busy_reg;
                iss_reg.t         <= t_reg;
                iss_reg.pts       <= pts_reg;
                iss_reg.meta.idx  <= idx_reg;
                iss_reg.meta.last <= last_now;
            end
        end
    end

    // Load a new curve or advance t; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pts_reg.sx <= curve.start_x;
            pts_reg.sy <= curve.start_y;
            pts_reg.ex <= curve.end_x;
            pts_reg.ey <= curve.end_y;
            idx_reg    <= '0;
            t_reg      <= '0;
            r_reg      <= seg_eff >> 1;
        end
        else if (adv && busy_reg)
        begin
            idx_reg <= idx_reg + SEG_W'(1);
            t_reg   <= t_next;
            r_reg   <= r_next;
        end
    end

    cblt_pipe u_pipe (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .iss   (iss_reg),
        .out   (pout)
    );

    assign point.valid       = pout.valid;
    assign point.point_x     = pout.x;
    assign point.point_y     = pout.y;
    assign point.point_index = pout.idx;
    assign point.last_point  = pout.last;

    // Points of one curve leave back to back
    `CBLT_ASSERT_NXT(a_curve_contig, clk, rst_n, point.valid && point.ready && !point.last_point, point.valid)
    // The final point carries the segment count as its index
    `CBLT_ASSERT_IMP(a_last_index, clk, rst_n, point.valid && point.last_point, point.point_index == seg_eff)
    // The start point is never the final one
    `CBLT_ASSERT_IMP(a_start_not_last, clk, rst_n, point.valid && (point.point_index == '0), !point.last_point)

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the cubic Bezier link tessellator unit.
// Depends on cblt_pkg, the cblt_curve_if / cblt_point_if interfaces and the top level RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cblt_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_ITEMS = 450;
    localparam longint unsigned T_UNIT = 64'd65536;

    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic [SEG_W-1:0]        idx;
        logic                    last;
    } point_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [SEG_W-1:0] cfg_wr_data;

    cblt_curve_if curve_ch ();
    cblt_point_if point_ch ();

    cubic_bezier_link_tessellator_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .curve       (curve_ch),
        .point       (point_ch)
    );

    // Shadow of the segment register and the points still owed by the block
    logic [SEG_W-1:0] segment_reg = SEG_RESET;
    point_t           owed_points[$];
    int               errors = 0;
    int               curves_sent = 0;
    bit               src_idle = 1'b0;
    bit               sink_idle = 1'b0;
    int               sink_hold = 0;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Gap length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
        begin
            return $urandom_range(0, 2);
        end
        return $urandom_range(3, 24);
    endfunction

    // Round a Q.48 weight product to Q.32, half up
    function automatic longint round_weight(input longint unsigned w);
        return longint'((w + 64'd32768) >> 16);
    endfunction

    // Round a 2^-33 LSB sum to nearest (ties up) and clamp to Q12.4
    function automatic logic signed [CRD_W-1:0] round_clamp(input longint s);
        longint r;
        r = (s + (longint'(1) << 32)) >>> 33;
        if (r > 32767)
        begin
            r = 32767;
        end
        if (r < -32768)
        begin
            r = -32768;
        end
        return CRD_W'(r);
    endfunction

    // Queue the points expected for one accepted curve transaction
    task automatic tessellate_curve(input cblt_pts_t c);
        longint          sx;
        longint          sy;
        longint          ex;
        longint          ey;
        longint unsigned segs;
        longint unsigned t;
        longint unsigned u;
        longint          w1;
        longint          w2;
        longint          w3;
        longint          w4;
        point_t          p;
        sx = longint'(c.sx);
        sy = longint'(c.sy);
        ex = longint'(c.ex);
        ey = longint'(c.ey);
        // A zero count acts as one segment; six bits never exceed the maximum
        segs = (segment_reg == '0) ? 64'd1 : longint'(segment_reg);
        p.x = c.sx;
        p.y = c.sy;
        p.idx = '0;
        p.last = 1'b0;
        owed_points = {owed_points, p};
        for (longint unsigned i = 1; i <= segs; i++)
        begin
            t = (i * T_UNIT + segs / 2) / segs;
            u = T_UNIT - t;
            w1 = round_weight(u * u * u);
            w2 = round_weight(3 * u * u * t);
            w3 = round_weight(3 * u * t * t);
            w4 = round_weight(t * t * t);
            p.x = round_clamp(w1 * (2 * sx) + (w2 + w3) * (sx + ex) + w4 * (2 * ex));
            p.y = round_clamp((w1 + w2) * (2 * sy) + (w3 + w4) * (2 * ey));
            p.idx = SEG_W'(i);
            p.last = (i == segs);
            owed_points = {owed_points, p};
        end
    endtask

    function automatic cblt_pts_t make_curve(input int sx, input int sy,
                                             input int ex, input int ey);
        cblt_pts_t c;
        c.sx = CRD_W'(sx);
        c.sy = CRD_W'(sy);
        c.ex = CRD_W'(ex);
        c.ey = CRD_W'(ey);
        return c;
    endfunction

    // Random coordinate, biased toward the ends of the range and toward zero
    function automatic int rand_coord();
        case ($urandom_range(0, 7))
            0: return ($urandom_range(0, 1) == 0) ? -32768 : 32767;
            1: return $urandom_range(0, 1) ? 0 : -1;
            2: return int'($urandom_range(0, 64)) - 32;
            default: return int'($signed(CRD_W'($urandom)));
        endcase
    endfunction

    function automatic cblt_pts_t rand_curve();
        cblt_pts_t c;
        c = make_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        // Sometimes keep both ends close together
        if ($urandom_range(0, 7) == 0)
        begin
            c.ex = c.sx + CRD_W'(int'($urandom_range(0, 32)) - 16);
            c.ey = c.sy + CRD_W'(int'($urandom_range(0, 32)) - 16);
        end
        return c;
    endfunction

    // Send one curve transaction and queue its expected points on acceptance
    task automatic send_curve(input cblt_pts_t c);
        int gap;
        gap = src_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            curve_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        curve_ch.valid <= 1'b1;
        curve_ch.start_x <= c.sx;
        curve_ch.start_y <= c.sy;
        curve_ch.end_x <= c.ex;
        curve_ch.end_y <= c.ey;
        @(posedge clk);
        while (!curve_ch.ready)
        begin
            @(posedge clk);
        end
        tessellate_curve(c);
        curves_sent++;
    endtask

    // Drop valid and wait until every owed point has come out
    task automatic drain_points();
        curve_ch.valid <= 1'b0;
        while (owed_points.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Write the segment count once the block is idle
    task automatic write_segments(input logic [SEG_W-1:0] value);
        drain_points();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        segment_reg = value;
    endtask

    // Extremes of every field at the reset segment count
    task automatic test_reset_count();
        src_idle = 1'b0;
        sink_idle = 1'b0;
        send_curve(make_curve(0, 0, 0, 0));
        send_curve(make_curve(-32768, -32768, 32767, 32767));
        send_curve(make_curve(32767, 32767, -32768, -32768));
        send_curve(make_curve(32767, -32768, 32767, -32768));
        send_curve(make_curve(-32768, 32767, -32768, 32767));
        send_curve(make_curve(32767, 32767, 32767, 32767));
        send_curve(make_curve(-32768, -32768, -32768, -32768));
        send_curve(make_curve(-1, -1, -1, -1));
        send_curve(make_curve(100, -200, -300, 400));
    endtask

    // Zero count, one segment, the maximum and back to a small count
    task automatic test_segment_extremes();
        src_idle = 1'b1;
        sink_idle = 1'b1;
        write_segments('0);
        send_curve(make_curve(-32768, 32767, 32767, -32768));
        send_curve(make_curve(5, 7, -9, 11));
        write_segments(SEG_W'(1));
        send_curve(make_curve(32767, -32768, -32768, 32767));
        send_curve(make_curve(-17, 33, 250, -4));
        write_segments(SEG_W'(63));
        send_curve(make_curve(-32768, -32768, 32767, 32767));
        send_curve(make_curve(32767, 0, -32768, -1));
        write_segments(SEG_W'(2));
        send_curve(make_curve(1, -1, -2, 2));
        send_curve(make_curve(32767, 32767, 32767, 32767));
    endtask

    // Random curves in phases of random segment count and idle pattern
    task automatic test_random_curves();
        int               count;
        logic [SEG_W-1:0] segs;
        count = 0;
        while (count < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: segs = SEG_W'(63);
                1: segs = '0;
                default: segs = SEG_W'($urandom_range(1, 20));
            endcase
            write_segments(segs);
            // One phase in five is forced to run with no idling at all
            if ($urandom_range(0, 4) == 0)
            begin
                src_idle = 1'b0;
                sink_idle = 1'b0;
            end
            else
            begin
                src_idle = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
            end
            for (int n = (segs == SEG_W'(63)) ? $urandom_range(3, 8) : $urandom_range(10, 40);
                 n > 0 && count < RANDOM_ITEMS; n--)
            begin
                send_curve(rand_curve());
                count++;
            end
        end
    endtask

    // Point sink: random stalls when enabled
    initial
    begin
        point_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                point_ch.ready <= 1'b0;
                sink_hold--;
            end
            else
            begin
                point_ch.ready <= 1'b1;
                if (sink_idle && $urandom_range(0, 2) == 0)
                begin
                    sink_hold = pick_gap();
                end
            end
        end
    end

    // Compare each point transaction with the oldest owed point
    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && point_ch.valid && point_ch.ready)
        begin
            if (owed_points.size() == 0)
            begin
                $error("unexpected point: x=%0d y=%0d index=%0d last=%0b",
                       point_ch.point_x, point_ch.point_y, point_ch.point_index,
                       point_ch.last_point);
                errors++;
            end
            else
            begin
                want = owed_points.pop_front();
                if (point_ch.point_x !== want.x)
                begin
                    $error("point_x: expected %0d, got %0d", want.x, point_ch.point_x);
                    errors++;
                end
                if (point_ch.point_y !== want.y)
                begin
                    $error("point_y: expected %0d, got %0d", want.y, point_ch.point_y);
                    errors++;
                end
                if (point_ch.point_index !== want.idx)
                begin
                    $error("point_index: expected %0d, got %0d", want.idx,
                           point_ch.point_index);
                    errors++;
                end
                if (point_ch.last_point !== want.last)
                begin
                    $error("last_point: expected %0b, got %0b", want.last,
                           point_ch.last_point);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    // Reset, run the tests in turn, drain and report
    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        curve_ch.valid <= 1'b0;
        curve_ch.start_x <= '0;
        curve_ch.start_y <= '0;
        curve_ch.end_x <= '0;
        curve_ch.end_y <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_count();
        test_segment_extremes();
        test_random_curves();

        drain_points();
        repeat (32) @(posedge clk);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
